/* src/tcnp_pkg.sv */
// Shared types, character codes and helpers for the text command number parser.
package tcnp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned MagW   = 15;
  localparam int unsigned ValW   = 16;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned LiftW  = 15;
  localparam int unsigned OutW   = 40;
  localparam int unsigned ProdW  = MagW + 4;

  localparam logic [LiftW-1:0] DefaultLiftReset = LiftW'(15);
  localparam logic [MagW-1:0]  MagMax           = MagW'(32767);

  localparam logic [ByteW-1:0] ChPass  = 8'h01;
  localparam logic [ByteW-1:0] ChSlash = 8'h2f;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChU     = 8'h75;
  localparam logic [ByteW-1:0] ChD     = 8'h64;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  typedef enum logic [CmdW-1:0] {
    CmdNone = 3'd0,
    CmdPass = 3'd1,
    CmdPos  = 3'd2,
    CmdUp   = 3'd3,
    CmdDown = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PhFirst   = 3'd0,
    PhLetter  = 3'd1,
    PhSkip    = 3'd2,
    PhN1Start = 3'd3,
    PhN1Dig   = 3'd4,
    PhN2Start = 3'd5,
    PhN2Dig   = 3'd6,
    PhDone    = 3'd7
  } phase_e;

  typedef struct packed {
    cmd_e                  command;
    logic signed [ValW-1:0] first_value;
    logic signed [ValW-1:0] second_value;
  } result_t;

  function automatic logic signed [ValW-1:0] apply_sign(input logic neg,
                                                       input logic [MagW-1:0] mag);
    logic [ValW-1:0] m;
    m = {1'b0, mag};
    return neg ? $signed(~m + ValW'(1)) : $signed(m);
  endfunction

endpackage

/* src/text_command_number_parser.sv */
// Top level: byte stream in, one decoded command beat out per message.
//
//  channel   direction  payload (low bit up)                         marker
//  s_axis    in         data_byte[7:0]                               tlast = end_of_message
//  m_axis    out        command[2:0], first_value[18:3],
//                       second_value[34:19], zero[39:35]             -
//  cfg       in         default_lift[14:0]                           write enable
//
// One byte per cycle while s_axis_tready is high; the parse state updates in the cycle a beat is taken.
// The result beat is registered and appears the cycle after the final byte.
// Input is taken whenever the result register is empty or being drained.
// Reset clears the parse state and the result valid flag; default_lift resets to 15.
module text_command_number_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // command[2:0], first_value[18:3], second_value[34:19]
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);
  import tcnp_pkg::*;

  logic              beat;
  logic [LiftW-1:0]  lift_q;
  logic              out_valid_q, out_valid_d;
  result_t           res;
  result_t           res_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  tcnp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .byte_i         (s_axis_tdata),
    .last_i         (s_axis_tlast),
    .default_lift_i (lift_q),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lift_q <= DefaultLiftReset;
    end else if (cfg_we_i) begin
      lift_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (beat && s_axis_tlast) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && s_axis_tlast) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.second_value, res_q.first_value, res_q.command};

`ifndef SYNTH
  a_idle_no_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] == CmdNone || m_axis_tdata[2:0] == CmdPass)
    |-> m_axis_tdata[34:3] == '0)
    else $error("values set on a command without numbers");

  a_second_only_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2:0] != CmdPos |-> m_axis_tdata[34:19] == '0)
    else $error("second value set on a non-position command");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");
`endif

endmodule

/* src/tcnp_parser.sv */
// Per-byte parse state and the decoded result for the final byte of a message.
module tcnp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         beat_i,
  input  logic [7:0]                   byte_i,
  input  logic                         last_i,
  input  logic [14:0]                  default_lift_i,
  output tcnp_pkg::result_t            result_o
);
  import tcnp_pkg::*;

  phase_e                phase_q, phase_d;
  cmd_e                  cmd_q, cmd_d;
  logic                  neg_q, neg_d;
  logic [MagW-1:0]       mag_q, mag_d;
  logic signed [ValW-1:0] first_q, first_d;

  logic                  is_digit;
  logic [ProdW-1:0]      prod;
  logic [MagW-1:0]       mag_added;
  logic signed [ValW-1:0] cur_q, cur_d;

  assign is_digit  = byte_i inside {[ChZero:ChNine]};
  assign prod      = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
                     + ProdW'(byte_i - ChZero);
  assign mag_added = (prod > ProdW'(MagMax)) ? MagMax : prod[MagW-1:0];
  assign cur_q     = apply_sign(neg_q, mag_q);

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    first_d = first_q;
    case (phase_q)
      PhFirst: begin
        if (byte_i == ChPass) begin
          cmd_d   = CmdPass;
          phase_d = PhDone;
        end else if (byte_i == ChSlash) begin
          phase_d = PhLetter;
        end else begin
          phase_d = PhDone;
        end
      end
      PhLetter: begin
        phase_d = PhSkip;
        if (byte_i == ChP) begin
          cmd_d = CmdPos;
        end else if (byte_i == ChU) begin
          cmd_d = CmdUp;
        end else if (byte_i == ChD) begin
          cmd_d = CmdDown;
        end else begin
          phase_d = PhDone;
        end
      end
      PhSkip: begin
        phase_d = PhN1Start;
      end
      PhN1Start, PhN2Start, PhN1Dig, PhN2Dig: begin
        if (is_digit) begin
          mag_d   = mag_added;
          phase_d = (phase_q inside {PhN1Start, PhN1Dig}) ? PhN1Dig : PhN2Dig;
        end else if (byte_i == ChMinus && phase_q inside {PhN1Start, PhN2Start}) begin
          neg_d   = 1'b1;
          phase_d = (phase_q == PhN1Start) ? PhN1Dig : PhN2Dig;
        end else if (cmd_q == CmdPos && phase_q inside {PhN1Start, PhN1Dig}) begin
          first_d = cur_q;
          neg_d   = 1'b0;
          mag_d   = '0;
          phase_d = PhN2Start;
        end else begin
          phase_d = PhDone;
        end
      end
      default: begin
      end
    endcase
  end

  assign cur_d = apply_sign(neg_d, mag_d);

  always_comb begin
    result_o              = '0;
    result_o.command      = cmd_d;
    case (cmd_d)
      CmdPos: begin
        if (phase_d inside {PhN2Start, PhN2Dig, PhDone}) begin
          result_o.first_value  = first_d;
          result_o.second_value = cur_d;
        end else begin
          result_o.first_value  = cur_d;
        end
      end
      CmdUp: begin
        result_o.first_value = (cur_d == '0) ? $signed({1'b0, default_lift_i}) : cur_d;
      end
      CmdDown: begin
        result_o.first_value = cur_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      cmd_q   <= CmdNone;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      first_q <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        phase_q <= PhFirst;
        cmd_q   <= CmdNone;
        neg_q   <= 1'b0;
        mag_q   <= '0;
        first_q <= '0;
      end else begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        first_q <= first_d;
      end
    end
  end

endmodule
